// ===== sv/idafs_pkg.sv =====
`timescale 1ns / 1ps

package idafs_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int ID_W         = 10;
    localparam int ST_W         = 2;

    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_RELEASE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic accept;
        logic exec;
    } t_cmd;

endpackage

// ===== sv/idafs_ram.sv =====
`timescale 1ns / 1ps

module idafs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/idafs_ctrl.sv =====
`timescale 1ns / 1ps

module idafs_ctrl
    import idafs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.exec   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state == S_EXEC);

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> busy)
        else $error("Accepted request did not make the controller busy.");

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> !o_cmd.exec)
        else $error("Execute cycle repeated.");

endmodule

// ===== sv/idafs_dp.sv =====
`timescale 1ns / 1ps

module idafs_dp
    import idafs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    input  logic            i_operation,
    input  logic [ID_W-1:0] i_release_id,
    output logic            o_done,
    output logic [ID_W-1:0] o_granted_id,
    output logic [ST_W-1:0] o_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + ID_W;
    localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);

    logic            r_op;
    logic [ID_W-1:0] r_rid;
    logic [CW-1:0]   r_depth;
    logic [CW-1:0]   n_depth;
    logic [CW-1:0]   r_hw;
    logic [CW-1:0]   n_hw;
    logic            r_done;
    logic [ID_W-1:0] r_granted;
    logic [ID_W-1:0] n_granted;
    logic [ST_W-1:0] r_status;
    logic [ST_W-1:0] n_status;

    logic            st_we;
    logic [ID_W-1:0] st_rdata;
    logic            iu_we;
    logic [AW-1:0]   iu_waddr;
    logic            iu_wdata;
    logic            iu_rdata;
    logic            rel_bad;

    // The in-use bit of an identifier below the high-water mark was always
    // written when it was issued, so the bit store needs no clearing.
    idafs_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_stack (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(AW'(r_depth)),
        .i_wdata(r_rid),
        .i_re   (i_cmd.accept),
        .i_raddr(AW'(r_depth - CW'(1))),
        .o_rdata(st_rdata)
    );

    idafs_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_in_use (
        .i_clk  (i_clk),
        .i_we   (iu_we),
        .i_waddr(iu_waddr),
        .i_wdata(iu_wdata),
        .i_re   (i_cmd.accept),
        .i_raddr(AW'(i_release_id)),
        .o_rdata(iu_rdata)
    );

    assign rel_bad = (XW'(r_rid) >= XW'(r_hw)) || !iu_rdata || (r_depth >= CAP_V);

    always_comb begin
        n_depth   = r_depth;
        n_hw      = r_hw;
        st_we     = 1'b0;
        iu_we     = 1'b0;
        iu_waddr  = AW'(r_rid);
        iu_wdata  = 1'b0;
        n_granted = '0;
        n_status  = ST_OK;
        if (r_op == OP_ALLOCATE) begin
            if (r_depth != '0) begin
                n_depth   = r_depth - CW'(1);
                iu_we     = i_cmd.exec;
                iu_waddr  = AW'(st_rdata);
                iu_wdata  = 1'b1;
                n_granted = st_rdata;
            end else if (r_hw < CAP_V) begin
                n_hw      = r_hw + CW'(1);
                iu_we     = i_cmd.exec;
                iu_waddr  = AW'(r_hw);
                iu_wdata  = 1'b1;
                n_granted = ID_W'(r_hw);
            end else begin
                n_status = ST_FULL;
            end
        end else begin
            if (rel_bad) begin
                n_status = ST_IGNORED;
            end else begin
                n_depth  = r_depth + CW'(1);
                st_we    = i_cmd.exec;
                iu_we    = i_cmd.exec;
                iu_wdata = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_operation;
            r_rid <= i_release_id;
        end
        if (i_cmd.exec) begin
            r_granted <= n_granted;
            r_status  <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_hw    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_depth <= n_depth;
                r_hw    <= n_hw;
            end
        end
    end

    assign o_done       = r_done;
    assign o_granted_id = r_granted;
    assign o_status     = r_status;

    a_depth_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CAP_V)
        else $error("Free stack depth exceeds the capacity.");

    a_depth_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_hw)
        else $error("More free identifiers than were ever issued.");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> o_done)
        else $error("Executed request produced no result.");

    a_fail_grants_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_granted_id == '0))
        else $error("Failed request carries a nonzero identifier.");

endmodule

// ===== sv/id_allocator_free_stack.sv =====
`timescale 1ns / 1ps

// Channel   Handshake            Ports
// request   start, busy          i_operation, i_release_id
// result    o_done (strobe)      o_granted_id, o_status
//
// A request is taken when start is high and busy is low. Both stores are read at
// that edge; the following cycle, while busy is high, decides and writes back.
// The result strobe is high in the cycle after that, when the next request may
// already be taken, so a new request is taken only once the last is written back.
// Synchronous active-low reset empties the stack and clears the high-water count;
// no memory sweep is needed. The receiver cannot stall the result.

module id_allocator_free_stack
    import idafs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            i_operation,
    input  logic [ID_W-1:0] i_release_id,
    output logic            o_done,
    output logic [ID_W-1:0] o_granted_id,
    output logic [ST_W-1:0] o_status
);

    t_cmd cmd;

    idafs_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .o_cmd  (cmd)
    );

    idafs_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_operation (i_operation),
        .i_release_id(i_release_id),
        .o_done      (o_done),
        .o_granted_id(o_granted_id),
        .o_status    (o_status)
    );

endmodule
